// ===== rtl/core/erpd_pkg.sv =====
// Shared constants, codes and payload types of the escape RLE palette decoder.
package erpd_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int COUNT_BITS      = 24;
	localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int CNT_W           = COUNT_BITS + 1;
	localparam int RGB_W           = 24;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 24;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_DATA  = 2'd1;
	localparam logic [1:0] MODE_START = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_TOTAL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_FULL = 2'd2;

	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] entry_index;
		logic [7:0] blue_in;
		logic [7:0] green_in;
		logic [7:0] red_in;
		logic [7:0] code_byte;
		logic       stream_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  pixel_value;
		logic [7:0]  run_length;
		logic [23:0] pixel_position;
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
		logic [7:0]  alpha_out;
		logic        record_done;
		logic        complete;
		logic        overrun;
	} out_item_t;

endpackage

// ===== rtl/core/erpd_in_if.sv =====
// Input request channel of the decoder: palette loads, record starts and stream bytes.
interface erpd_in_if;
	import erpd_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/erpd_out_if.sv =====
// Result channel of the decoder: one request per literal, run or status.
interface erpd_out_if;
	import erpd_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/erpd_cfg_if.sv =====
// Configuration write channel of the decoder.
interface erpd_cfg_if;
	import erpd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/erpd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module erpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/escape_rle_palette_decoder.sv =====
// Top level of the escape RLE palette decoder: stream parser, palette RAM and result stage.
//
//   channel   | direction | request carries
//   ----------+-----------+--------------------------------------------------
//   cfg       | in        | register index, write data
//   pix_in    | in        | mode, palette entry and colour, code byte, end mark
//   pix_out   | out       | index, length, position, colour, alpha, status
//
// One request is accepted per cycle while the result stage can drain; a result is
// registered first with the parser and the palette RAM read, then in the output register.
// Reset clears the parser, the counters and the configuration; the palette RAM
// holds no reset value and must be loaded before colours are used.
// A stalled output holds the result stage and the RAM read data, and the input
// stays ready as long as the result stage can drain.
module escape_rle_palette_decoder (
	input logic clk,
	input logic arst_n,
	erpd_cfg_if.sink cfg,
	erpd_in_if.sink pix_in,
	erpd_out_if.source pix_out
);
	import erpd_pkg::*;

	typedef enum logic [2:0] {
		PH_NORMAL = 3'b001,
		PH_VALUE  = 3'b010,
		PH_COUNT  = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0]  pixel_value;
		logic [7:0]  run_length;
		logic [23:0] pixel_position;
		logic        with_colour;
		logic        in_range;
		logic        record_done;
		logic        complete;
		logic        overrun;
	} stage_t;

	logic [7:0]            escape_q;
	logic [COUNT_BITS-1:0] total_q;
	logic                  full_q;

	phase_t           phase_q, phase_d;
	logic [7:0]       held_q, held_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             ovr_q, ovr_d;

	logic             s1_valid_q;
	stage_t           s1_q, s1_d;
	logic             out_valid_q;
	out_item_t        out_q;

	logic             in_acc, out_load, emit, run;
	logic [7:0]       run_value, run_count;
	logic [CNT_W-1:0] total_ext, remaining;
	logic             below_total, over;
	logic             pal_we, pal_re;
	logic [RGB_W-1:0] pal_rdata, rgb;
	in_item_t         item;

	assign item        = pix_in.payload;
	assign cfg.ready   = 1'b1;
	assign out_load    = s1_valid_q && (!out_valid_q || pix_out.ready);
	assign pix_in.ready = !s1_valid_q || out_load;
	assign in_acc      = pix_in.valid && pix_in.ready;
	assign total_ext   = {1'b0, total_q};
	assign below_total = cnt_q < total_ext;
	assign remaining   = total_ext - cnt_q;
	assign over        = {{(CNT_W-8){1'b0}}, run_count} > remaining;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= '0;
			total_q  <= '0;
			full_q   <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_ESCAPE_CODE:  escape_q <= cfg.data[7:0];
				CFG_PIXEL_TOTAL:  total_q  <= COUNT_BITS'(cfg.data);
				CFG_PALETTE_FULL: full_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d   = phase_q;
		held_d    = held_q;
		cnt_d     = cnt_q;
		ovr_d     = ovr_q;
		emit      = 1'b0;
		run       = 1'b0;
		run_value = '0;
		run_count = '0;
		pal_we    = 1'b0;
		if (in_acc) begin
			case (item.mode)
				MODE_LOAD: begin
					pal_we = int'(item.entry_index) < PALETTE_ENTRIES;
				end
				MODE_START: begin
					phase_d = PH_NORMAL;
					held_d  = '0;
					cnt_d   = '0;
					ovr_d   = 1'b0;
				end
				MODE_DATA: begin
					if (!below_total) begin
						emit = item.stream_end;
					end else begin
						case (phase_q)
							PH_VALUE: begin
								held_d = item.code_byte;
								if (item.stream_end) begin
									phase_d = PH_NORMAL;
									emit    = 1'b1;
								end else begin
									phase_d = PH_COUNT;
								end
							end
							PH_COUNT: begin
								phase_d   = PH_NORMAL;
								run       = 1'b1;
								run_value = held_q;
								run_count = item.code_byte;
							end
							default: begin
								phase_d = PH_NORMAL;
								if (item.code_byte == escape_q) begin
									if (item.stream_end) begin
										emit = 1'b1;
									end else begin
										phase_d = PH_VALUE;
									end
								end else begin
									run       = 1'b1;
									run_value = item.code_byte;
									run_count = 8'd1;
								end
							end
						endcase
					end
				end
				default: ;
			endcase
		end
		if (run) begin
			emit  = 1'b1;
			cnt_d = cnt_q + CNT_W'(run_count);
			if (over) begin
				ovr_d = 1'b1;
			end
		end
		pal_re = run;

		s1_d.pixel_value    = run_value;
		s1_d.run_length     = (run && over) ? remaining[7:0] : run_count;
		s1_d.pixel_position = below_total ? 24'(cnt_q[COUNT_BITS-1:0]) : 24'(total_q);
		s1_d.with_colour    = run;
		s1_d.in_range       = int'(run_value) < PALETTE_ENTRIES;
		s1_d.record_done    = item.stream_end;
		s1_d.complete       = cnt_d == total_ext;
		s1_d.overrun        = ovr_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
			held_q  <= '0;
			cnt_q   <= '0;
			ovr_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			held_q  <= held_d;
			cnt_q   <= cnt_d;
			ovr_q   <= ovr_d;
		end
	end

	erpd_ram #(
		.WIDTH(RGB_W),
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk  (clk),
		.we   (pal_we),
		.waddr(item.entry_index[PAL_AW-1:0]),
		.wdata({item.red_in, item.green_in, item.blue_in}),
		.re   (pal_re),
		.raddr(run_value[PAL_AW-1:0]),
		.rdata(pal_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc && emit) begin
			s1_valid_q <= 1'b1;
		end else if (out_load) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			s1_q <= s1_d;
		end
	end

	assign rgb = (s1_q.with_colour && full_q && s1_q.in_range) ? pal_rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.pixel_value    <= s1_q.pixel_value;
			out_q.run_length     <= s1_q.run_length;
			out_q.pixel_position <= s1_q.pixel_position;
			out_q.red_out        <= rgb[23:16];
			out_q.green_out      <= rgb[15:8];
			out_q.blue_out       <= rgb[7:0];
			out_q.alpha_out      <= (s1_q.with_colour && full_q && s1_q.pixel_value != 8'd0)
				? ALPHA_OPAQUE : 8'd0;
			out_q.record_done    <= s1_q.record_done;
			out_q.complete       <= s1_q.complete;
			out_q.overrun        <= s1_q.overrun;
		end
	end

	assign pix_out.valid   = out_valid_q;
	assign pix_out.payload = out_q;

	// The palette read data must survive while the result stage is stalled.
	a_stall_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !out_load) |-> !pal_re)
		else $error("palette read issued while the result stage is stalled");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !out_load) |=> (s1_valid_q && $stable(s1_q)))
		else $error("stalled result stage changed");

	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_q.with_colour) |-> (s1_q.record_done && s1_q.run_length == 8'd0))
		else $error("status-only result without end mark or with a length");

endmodule

// ===== verif/erpd_tb_pkg.sv =====
// Scoreboard with the decode predictor used by the escape RLE palette decoder testbench.
package erpd_tb_pkg;
	import erpd_pkg::*;

	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_VALUE  = 2'd1,
		PH_COUNT  = 2'd2
	} parse_phase_t;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [1:0]           MODE_SPARE = 2'd3;

	class pixel_run_scoreboard;
		logic [7:0]       escape_code;
		logic [23:0]      pixel_total;
		logic             palette_full;
		parse_phase_t     phase;
		logic [7:0]       held_value;
		logic [CNT_W-1:0] produced;
		logic             overrun_seen;
		logic [RGB_W-1:0] palette [PALETTE_ENTRIES];
		out_item_t        pending_runs [$];
		int               mismatches;
		int               results_checked;
		int               run_results;
		int               status_results;
		int               overrun_results;

		function new();
			escape_code = '0;
			pixel_total = '0;
			palette_full = 1'b0;
			foreach (palette[i])
				palette[i] = '0;
			clear_record();
			mismatches = 0;
			results_checked = 0;
			run_results = 0;
			status_results = 0;
			overrun_results = 0;
		endfunction

		function void clear_record();
			phase = PH_NORMAL;
			held_value = '0;
			produced = '0;
			overrun_seen = 1'b0;
		endfunction

		function void queue_result(out_item_t r);
			pending_runs.insert(pending_runs.size(), r);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_ESCAPE_CODE: escape_code = data[7:0];
				CFG_PIXEL_TOTAL: pixel_total = data[23:0];
				CFG_PALETTE_FULL: palette_full = data[0];
				default: ;
			endcase
		endfunction

		function out_item_t make_result(logic [7:0] value, logic [7:0] len,
				logic [CNT_W-1:0] pos, logic with_colour, logic done);
			out_item_t r;
			logic [RGB_W-1:0] rgb;
			r = '0;
			rgb = '0;
			r.pixel_value = value;
			r.run_length = len;
			r.pixel_position = pos[23:0];
			if (with_colour && palette_full) begin
				if (int'(value) < PALETTE_ENTRIES)
					rgb = palette[value];
				r.alpha_out = (value == 8'd0) ? 8'd0 : ALPHA_OPAQUE;
			end
			r.red_out = rgb[23:16];
			r.green_out = rgb[15:8];
			r.blue_out = rgb[7:0];
			r.record_done = done;
			r.complete = (produced == {1'b0, pixel_total});
			r.overrun = overrun_seen;
			return r;
		endfunction

		function void status_result();
			logic [CNT_W-1:0] pos;
			pos = (produced < {1'b0, pixel_total}) ? produced : {1'b0, pixel_total};
			queue_result(make_result(8'd0, 8'd0, pos, 1'b0, 1'b1));
			status_results++;
		endfunction

		function void run_result(logic [7:0] value, logic [7:0] count, logic done);
			logic [CNT_W-1:0] remaining;
			logic [CNT_W-1:0] pos;
			logic [7:0] len;
			remaining = {1'b0, pixel_total} - produced;
			pos = produced;
			len = count;
			if (CNT_W'(count) > remaining) begin
				len = remaining[7:0];
				overrun_seen = 1'b1;
			end
			produced = produced + CNT_W'(count);
			queue_result(make_result(value, len, pos, 1'b1, done));
			run_results++;
			if (overrun_seen)
				overrun_results++;
		endfunction

		function void decode_byte(logic [7:0] code, logic last);
			if (produced >= {1'b0, pixel_total}) begin
				if (last)
					status_result();
				return;
			end
			case (phase)
				PH_VALUE: begin
					held_value = code;
					if (last) begin
						phase = PH_NORMAL;
						status_result();
					end else begin
						phase = PH_COUNT;
					end
				end
				PH_COUNT: begin
					phase = PH_NORMAL;
					run_result(held_value, code, last);
				end
				default: begin
					phase = PH_NORMAL;
					if (code == escape_code) begin
						if (last)
							status_result();
						else
							phase = PH_VALUE;
					end else begin
						run_result(code, 8'd1, last);
					end
				end
			endcase
		endfunction

		function void note_request(in_item_t it);
			case (it.mode)
				MODE_LOAD: begin
					if (int'(it.entry_index) < PALETTE_ENTRIES)
						palette[it.entry_index] = {it.red_in, it.green_in, it.blue_in};
				end
				MODE_START: clear_record();
				MODE_DATA: decode_byte(it.code_byte, it.stream_end);
				default: ;
			endcase
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= 100)
				$display("MISMATCH at result %0d: %s", results_checked, msg);
		endtask

		task compare_field(string name, logic [23:0] got, logic [23:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			results_checked++;
			if (pending_runs.size() == 0) begin
				report_mismatch($sformatf("result %h arrived with nothing expected", got));
				return;
			end
			want = pending_runs.pop_front();
			compare_field("pixel_value", 24'(got.pixel_value), 24'(want.pixel_value));
			compare_field("run_length", 24'(got.run_length), 24'(want.run_length));
			compare_field("pixel_position", got.pixel_position, want.pixel_position);
			compare_field("red_out", 24'(got.red_out), 24'(want.red_out));
			compare_field("green_out", 24'(got.green_out), 24'(want.green_out));
			compare_field("blue_out", 24'(got.blue_out), 24'(want.blue_out));
			compare_field("alpha_out", 24'(got.alpha_out), 24'(want.alpha_out));
			compare_field("record_done", 24'(got.record_done), 24'(want.record_done));
			compare_field("complete", 24'(got.complete), 24'(want.complete));
			compare_field("overrun", 24'(got.overrun), 24'(want.overrun));
		endtask
	endclass

endpackage

// ===== verif/tb_top.sv =====
// Top-level testbench of the escape RLE palette decoder: stimulus, handshakes and final verdict.
module tb_top;
	import erpd_pkg::*;
	import erpd_tb_pkg::*;

	localparam int ITEM_BUDGET   = 1950;
	localparam int PHASE_ITEMS   = 200;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 1000000;

	logic clk;
	logic arst_n;

	erpd_cfg_if cfg();
	erpd_in_if  pix_in();
	erpd_out_if pix_out();

	escape_rle_palette_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.pix_in(pix_in),
		.pix_out(pix_out)
	);

	pixel_run_scoreboard board;
	int cycles = 0;
	int sent_items = 0;
	int settings_used = 0;
	logic calm = 1'b0;
	logic [7:0] cur_escape = 8'd0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pix_in.valid && pix_in.ready)
			board.note_request(pix_in.payload);
		if (arst_n && pix_out.valid && pix_out.ready)
			board.check_result(pix_out.payload);
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	initial begin
		int stall;
		stall = 0;
		pix_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				pix_out.ready <= 1'b0;
				stall--;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				pix_out.ready <= 1'b0;
				stall = pick_gap();
			end else begin
				pix_out.ready <= 1'b1;
			end
		end
	end

	function automatic in_item_t rand_item(logic [1:0] mode);
		in_item_t it;
		it.mode = mode;
		it.entry_index = 8'($urandom);
		it.blue_in = 8'($urandom);
		it.green_in = 8'($urandom);
		it.red_in = 8'($urandom);
		it.code_byte = 8'($urandom);
		it.stream_end = 1'($urandom);
		return it;
	endfunction

	function automatic in_item_t data_item(logic [7:0] code, logic last);
		in_item_t it;
		it = rand_item(MODE_DATA);
		it.code_byte = code;
		it.stream_end = last;
		return it;
	endfunction

	function automatic in_item_t load_item(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
			logic [7:0] b);
		in_item_t it;
		it = rand_item(MODE_LOAD);
		it.entry_index = idx;
		it.red_in = r;
		it.green_in = g;
		it.blue_in = b;
		return it;
	endfunction

	function automatic logic [7:0] value_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'd0;
		if (r == 1)
			return 8'd255;
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] literal_byte();
		logic [7:0] b;
		b = value_byte();
		if (b == cur_escape)
			b = b + 8'd1;
		return b;
	endfunction

	function automatic logic [7:0] run_count();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'd0;
		if (r == 1)
			return 8'd255;
		if (r < 4)
			return 8'($urandom);
		return 8'($urandom_range(1, 8));
	endfunction

	task automatic send_req(in_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pix_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.payload <= it;
		@(posedge clk);
		while (!pix_in.ready)
			@(posedge clk);
		if (it.mode != MODE_SPARE)
			sent_items++;
	endtask

	task automatic send_data(logic [7:0] code, logic last);
		send_req(data_item(code, last));
	endtask

	task automatic send_run(logic [7:0] value, logic [7:0] count, logic last);
		send_data(cur_escape, 1'b0);
		send_data(value, 1'b0);
		send_data(count, last);
	endtask

	task automatic drain();
		pix_in.valid <= 1'b0;
		@(posedge clk);
		while (board.pending_runs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		board.write_reg(idx, data);
	endtask

	task automatic apply_setting(logic [7:0] esc, logic [23:0] total, logic full);
		drain();
		write_reg(CFG_ESCAPE_CODE, {16'($urandom), esc});
		write_reg(CFG_PIXEL_TOTAL, total);
		write_reg(CFG_PALETTE_FULL, {23'($urandom), full});
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_UNUSED, 24'($urandom));
		cfg.valid <= 1'b0;
		cur_escape = esc;
		settings_used++;
	endtask

	task automatic directed_checks();
		send_req(load_item(8'd255, 8'hFF, 8'hFF, 8'hFF));
		send_req(load_item(8'd0, 8'h00, 8'h00, 8'h00));
		send_req(rand_item(MODE_START));
		send_data(8'd0, 1'b0);
		send_data(8'd255, 1'b0);
		send_run(8'd5, 8'd3, 1'b0);
		send_run(8'd0, 8'd0, 1'b0);
		send_run(8'd200, 8'd255, 1'b0);
		send_data(8'd9, 1'b0);
		send_data(8'd9, 1'b1);
		send_req(rand_item(MODE_SPARE));
		send_req(rand_item(MODE_START));
		send_data(cur_escape, 1'b1);
		send_data(cur_escape, 1'b0);
		send_data(8'd44, 1'b1);
		send_run(8'd27, 8'd12, 1'b0);
		send_data(8'd1, 1'b1);
	endtask

	task automatic send_record();
		int tokens;
		int kind;
		logic fin;
		if ($urandom_range(0, 7) != 0)
			send_req(rand_item(MODE_START));
		if ($urandom_range(0, 3) == 0)
			calm = ~calm;
		tokens = $urandom_range(1, 24);
		for (int t = 0; t < tokens; t++) begin
			fin = (t == tokens - 1) && ($urandom_range(0, 9) != 0);
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				send_data(literal_byte(), fin);
			end else if (kind < 85) begin
				send_run(value_byte(), run_count(), fin);
			end else if (kind < 90) begin
				send_data(cur_escape, $urandom_range(0, 1) == 0 ? fin : 1'b0);
				if (board.phase == PH_VALUE || $urandom_range(0, 1) == 0)
					send_data(value_byte(), fin);
			end else if (kind < 94) begin
				send_req(rand_item(MODE_LOAD));
			end else if (kind < 97) begin
				send_req(rand_item(MODE_SPARE));
			end else begin
				send_data(8'($urandom), 1'($urandom));
			end
		end
	endtask

	task automatic pick_setting(int n);
		logic [7:0] esc;
		logic [23:0] total;
		logic full;
		int r;
		r = $urandom_range(0, 3);
		esc = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom);
		r = $urandom_range(0, 9);
		case (r)
			0: total = 24'd0;
			1: total = 24'd1;
			2: total = 24'hFFFFFF;
			3: total = 24'($urandom);
			4: total = 24'd255;
			5, 6: total = 24'($urandom_range(2, 64));
			default: total = 24'($urandom_range(65, 600));
		endcase
		full = ($urandom_range(0, 3) != 0);
		if (n == 0) begin
			esc = 8'd0;
			total = 24'd0;
			full = 1'b0;
		end else if (n == 1) begin
			esc = 8'd255;
			total = 24'hFFFFFF;
			full = 1'b1;
		end
		apply_setting(esc, total, full);
	endtask

	initial begin
		int base;
		int phase_start;
		int n;
		board = new();
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		pix_in.valid = 1'b0;
		pix_in.payload = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apply_setting(8'd27, 24'd12, 1'b1);
		for (int i = 0; i < PALETTE_ENTRIES; i++)
			send_req(load_item(8'(i), 8'($urandom), 8'($urandom), 8'($urandom)));
		directed_checks();

		base = 0;
		n = 0;
		while (sent_items - base < ITEM_BUDGET) begin
			pick_setting(n);
			n++;
			phase_start = sent_items;
			while (sent_items - phase_start < PHASE_ITEMS && sent_items - base < ITEM_BUDGET)
				send_record();
		end
		drain();

		$display("Covered %0d requests under %0d register settings, with long and short stalls.",
			sent_items, settings_used);
		$display("Checked %0d results: %0d runs or literals, %0d status-only, %0d with overrun.",
			board.results_checked, board.run_results, board.status_results,
			board.overrun_results);
		if (board.mismatches == 0 && board.pending_runs.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
